// ----- rtl/pid_deadband_feedforward_unit_assert.svh -----
// ----------------------------------------------------------------------------
// pid_deadband_feedforward_unit_assert.svh
// Assertion macros used by the checker of the PID deadband unit.
// ----------------------------------------------------------------------------
`ifndef PID_DEADBAND_FEEDFORWARD_UNIT_ASSERT_SVH
`define PID_DEADBAND_FEEDFORWARD_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define PDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pdf_pkg.sv -----
// ----------------------------------------------------------------------------
// pdf_pkg
// Widths, register map and clamp helper of the PID deadband feedforward unit.
// ----------------------------------------------------------------------------
package pdf_pkg;

    // Field widths
    localparam int DATA_W  = 16;   // samples, gains, drive limits
    localparam int ERR_W   = 17;   // setpoint minus measured
    localparam int ACC_W   = 32;   // accumulated error and its limits
    localparam int HELD_W  = 48;   // held P+I+D sum
    localparam int CLAMP_W = 49;   // widest value fed to the clamp
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Build-time defaults
    localparam int DEADBAND_DEF        = 0;
    localparam int DEADBAND_FREEZE_DEF = 0;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_GAIN_FF     = 3'd3;
    localparam logic [2:0] REG_INTEG_LOWER = 3'd4;
    localparam logic [2:0] REG_INTEG_UPPER = 3'd5;
    localparam logic [2:0] REG_DRIVE_LOWER = 3'd6;
    localparam logic [2:0] REG_DRIVE_UPPER = 3'd7;

    typedef logic signed [CLAMP_W-1:0] clamp_in_t;
    typedef logic signed [ACC_W-1:0]   limit_t;

    // Clamp v to the pair (a, b), whichever order the pair is in
    function automatic limit_t clamp_pair(clamp_in_t v, limit_t a, limit_t b);
        limit_t    lo;
        limit_t    hi;
        limit_t    res;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        if (v < CLAMP_W'(lo))
            res = lo;
        else if (v > CLAMP_W'(hi))
            res = hi;
        else
            res = v[ACC_W-1:0];
        return res;
    endfunction

endpackage

// ----- rtl/pid_deadband_feedforward_unit.sv -----
// ----------------------------------------------------------------------------
// pid_deadband_feedforward_unit
// Positional PID controller with deadband, clamped integral and feedforward.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries setpoint, measured and
//   ff_sample; a transfer happens on a clock edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall) carries drive,
//   in_deadband and loop_error, one result per input transfer, in order.
//   Gains and limits are written through the APB port while the unit idles.
// Pipeline: input register, error and integral update, four parallel gain
//   multipliers, P+I+D sum, drive clamp into the output register.
// Throughput: one item per cycle while the output is not stalled; the integral
//   and last-error update is a single clamp-add-clamp step, so the next item follows right away.
// Reset: all stages empty, gains, limits and controller state at zero.
// Stall: each stage holds when the one after it is full and held; in_stall
//   rises only once all five stages are full behind a stalled output.
// ----------------------------------------------------------------------------
module pid_deadband_feedforward_unit #(
    parameter int DEADBAND        = pdf_pkg::DEADBAND_DEF,
    parameter int DEADBAND_FREEZE = pdf_pkg::DEADBAND_FREEZE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pdf_pkg::PADDR_W-1:0]          paddr,
    input  logic [pdf_pkg::PDATA_W-1:0]          pwdata,
    output logic [pdf_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pdf_pkg::DATA_W-1:0]    setpoint,
    input  logic signed [pdf_pkg::DATA_W-1:0]    measured,
    input  logic signed [pdf_pkg::DATA_W-1:0]    ff_sample,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pdf_pkg::DATA_W-1:0]    drive,
    output logic                                 in_deadband,
    output logic signed [pdf_pkg::ERR_W-1:0]     loop_error
);
    import pdf_pkg::*;

    localparam logic signed [ERR_W:0] DB_POS     = (ERR_W+1)'(DEADBAND);
    localparam logic signed [ERR_W:0] DB_NEG     = -DB_POS;
    localparam bit                    FREEZE_ON  = (DEADBAND_FREEZE != 0);
    localparam int                    P_W        = DATA_W + ERR_W;       // 33
    localparam int                    I_W        = DATA_W + ACC_W;       // 48
    localparam int                    D_W        = DATA_W + ERR_W + 1;   // 34
    localparam int                    F_W        = 2 * DATA_W;           // 32

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, gain_ff_reg;
    logic signed [ACC_W-1:0]  integ_lower_reg, integ_upper_reg;
    logic signed [DATA_W-1:0] drive_lower_reg, drive_upper_reg;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            gain_ff_reg     <= '0;
            integ_lower_reg <= '0;
            integ_upper_reg <= '0;
            drive_lower_reg <= '0;
            drive_upper_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GAIN_P:      gain_p_reg      <= pwdata[DATA_W-1:0];
                REG_GAIN_I:      gain_i_reg      <= pwdata[DATA_W-1:0];
                REG_GAIN_D:      gain_d_reg      <= pwdata[DATA_W-1:0];
                REG_GAIN_FF:     gain_ff_reg     <= pwdata[DATA_W-1:0];
                REG_INTEG_LOWER: integ_lower_reg <= pwdata[ACC_W-1:0];
                REG_INTEG_UPPER: integ_upper_reg <= pwdata[ACC_W-1:0];
                REG_DRIVE_LOWER: drive_lower_reg <= pwdata[DATA_W-1:0];
                REG_DRIVE_UPPER: drive_upper_reg <= pwdata[DATA_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read mux, values sign-extended to the bus
    always_comb
    begin
        unique case (cfg_idx)
            REG_GAIN_P:      prdata = PDATA_W'(gain_p_reg);
            REG_GAIN_I:      prdata = PDATA_W'(gain_i_reg);
            REG_GAIN_D:      prdata = PDATA_W'(gain_d_reg);
            REG_GAIN_FF:     prdata = PDATA_W'(gain_ff_reg);
            REG_INTEG_LOWER: prdata = PDATA_W'(integ_lower_reg);
            REG_INTEG_UPPER: prdata = PDATA_W'(integ_upper_reg);
            REG_DRIVE_LOWER: prdata = PDATA_W'(drive_lower_reg);
            REG_DRIVE_UPPER: prdata = PDATA_W'(drive_upper_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when empty or when it moves on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5      = !out_valid_reg || !out_stall;
    assign ld4      = !s4_valid_reg  || ld5;
    assign ld3      = !s3_valid_reg  || ld4;
    assign ld2      = !s2_valid_reg  || ld3;
    assign ld1      = !s1_valid_reg  || ld2;
    assign in_stall = !ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                s1_valid_reg <= in_valid;
            if (ld2)
                s2_valid_reg <= s1_valid_reg;
            if (ld3)
                s3_valid_reg <= s2_valid_reg;
            if (ld4)
                s4_valid_reg <= s3_valid_reg;
            if (ld5)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] s1_setpoint_reg, s1_measured_reg, s1_ff_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_setpoint_reg <= setpoint;
            s1_measured_reg <= measured;
            s1_ff_reg       <= ff_sample;
        end
    end

    // ------------------------------------------------------------------
    // Error, deadband test, integral and last-error update
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] accum_reg, accum_next;
    logic signed [ERR_W-1:0] prior_reg, prior_next;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   err_ext;
    logic signed [ERR_W:0]   diff;
    logic                    dead;
    logic signed [ACC_W-1:0] accum_clamped;
    logic signed [ACC_W:0]   accum_sum;
    logic signed [ACC_W-1:0] accum_pid;

    always_comb
    begin
        err = $signed({s1_setpoint_reg[DATA_W-1], s1_setpoint_reg})
            - $signed({s1_measured_reg[DATA_W-1], s1_measured_reg});
        err_ext = $signed({err[ERR_W-1], err});
        dead    = (err_ext <= DB_POS) && (err_ext >= DB_NEG);
        diff    = err_ext - $signed({prior_reg[ERR_W-1], prior_reg});

        // stored integral is clamped to the current limits first
        accum_clamped = clamp_pair(CLAMP_W'(accum_reg), integ_lower_reg, integ_upper_reg);
        accum_sum     = (ACC_W+1)'(accum_clamped) + (ACC_W+1)'(err);
        accum_pid     = clamp_pair(CLAMP_W'(accum_sum), integ_lower_reg, integ_upper_reg);

        if (!dead)
        begin
            accum_next = accum_pid;
            prior_next = err;
        end
        else if (FREEZE_ON)
        begin
            accum_next = accum_clamped;
            prior_next = prior_reg;
        end
        else
        begin
            accum_next = '0;
            prior_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            prior_reg <= '0;
        end
        else if (s1_valid_reg && ld2)
        begin
            accum_reg <= accum_next;
            prior_reg <= prior_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: operands of the gain products
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]  s2_err_reg;
    logic                     s2_dead_reg;
    logic signed [ACC_W-1:0]  s2_accum_reg;
    logic signed [ERR_W:0]    s2_diff_reg;
    logic signed [DATA_W-1:0] s2_ff_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_err_reg   <= err;
            s2_dead_reg  <= dead;
            s2_accum_reg <= accum_next;
            s2_diff_reg  <= diff;
            s2_ff_reg    <= s1_ff_reg;
        end
    end

    // ------------------------------------------------------------------
    // Gain products, floor shift by 8 (drop the low byte)
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] p_prod;
    logic signed [I_W-1:0] i_prod;
    logic signed [D_W-1:0] d_prod;
    logic signed [F_W-1:0] f_prod;

    assign p_prod = P_W'(gain_p_reg)  * P_W'(s2_err_reg);
    assign i_prod = I_W'(gain_i_reg)  * I_W'(s2_accum_reg);
    assign d_prod = D_W'(gain_d_reg)  * D_W'(s2_diff_reg);
    assign f_prod = F_W'(gain_ff_reg) * F_W'(s2_ff_reg);

    // Stage 3: shifted terms
    logic signed [P_W-9:0]    s3_p_reg;
    logic signed [I_W-9:0]    s3_i_reg;
    logic signed [D_W-9:0]    s3_d_reg;
    logic signed [F_W-9:0]    s3_f_reg;
    logic                     s3_dead_reg;
    logic signed [ERR_W-1:0]  s3_err_reg;

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_p_reg    <= p_prod[P_W-1:8];
            s3_i_reg    <= i_prod[I_W-1:8];
            s3_d_reg    <= d_prod[D_W-1:8];
            s3_f_reg    <= f_prod[F_W-1:8];
            s3_dead_reg <= s2_dead_reg;
            s3_err_reg  <= s2_err_reg;
        end
    end

    // ------------------------------------------------------------------
    // P+I+D sum and held sum
    // ------------------------------------------------------------------
    logic signed [HELD_W-1:0] held_reg, held_next;
    logic signed [HELD_W-1:0] pid_sum;

    assign pid_sum = HELD_W'(s3_p_reg) + HELD_W'(s3_i_reg) + HELD_W'(s3_d_reg);

    always_comb
    begin
        if (!s3_dead_reg)
            held_next = pid_sum;
        else if (FREEZE_ON)
            held_next = held_reg;
        else
            held_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (s3_valid_reg && ld4)
            held_reg <= held_next;
    end

    // Stage 4: feedforward term and flags
    logic signed [F_W-9:0]   s4_f_reg;
    logic                    s4_dead_reg;
    logic signed [ERR_W-1:0] s4_err_reg;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_f_reg    <= s3_f_reg;
            s4_dead_reg <= s3_dead_reg;
            s4_err_reg  <= s3_err_reg;
        end
    end

    // ------------------------------------------------------------------
    // Drive sum and clamp into the output register
    // ------------------------------------------------------------------
    logic signed [CLAMP_W-1:0] drive_sum;
    logic signed [ACC_W-1:0]   drive_clamped;
    logic signed [DATA_W-1:0]  drive_reg;
    logic                      in_deadband_reg;
    logic signed [ERR_W-1:0]   loop_error_reg;

    assign drive_sum     = CLAMP_W'(held_reg) + CLAMP_W'(s4_f_reg);
    assign drive_clamped = clamp_pair(drive_sum, ACC_W'(drive_lower_reg),
                                      ACC_W'(drive_upper_reg));

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            drive_reg       <= drive_clamped[DATA_W-1:0];
            in_deadband_reg <= s4_dead_reg;
            loop_error_reg  <= s4_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;
    assign in_deadband = in_deadband_reg;
    assign loop_error  = loop_error_reg;

endmodule

// ----- rtl/pdf_checker.sv -----
// ----------------------------------------------------------------------------
// pdf_checker
// Port-level checks of the PID deadband feedforward unit, bound to its top.
// ----------------------------------------------------------------------------
`include "pid_deadband_feedforward_unit_assert.svh"

module pdf_checker #(
    parameter int DEADBAND = pdf_pkg::DEADBAND_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [pdf_pkg::DATA_W-1:0] drive,
    input logic                              in_deadband,
    input logic signed [pdf_pkg::ERR_W-1:0]  loop_error
);
    import pdf_pkg::*;

    localparam logic signed [ERR_W:0] DB_POS = (ERR_W+1)'(DEADBAND);
    localparam logic signed [ERR_W:0] DB_NEG = -DB_POS;

    logic signed [ERR_W:0] err_ext;
    logic                  err_in_band;

    assign err_ext     = $signed({loop_error[ERR_W-1], loop_error});
    assign err_in_band = (err_ext <= DB_POS) && (err_ext >= DB_NEG);

    // Deadband flag agrees with the error it is shown with
    `PDF_ASSERT_NOW(a_deadband_flag, out_valid, in_deadband == err_in_band, "deadband flag mismatch")

    // Input backpressure only once a result is held at the output
    `PDF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

    // A held result stays put until taken
    `PDF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive) && $stable(in_deadband) && $stable(loop_error), "stalled result changed")

    // A stalled input transfer is not withdrawn
    `PDF_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid, "input valid dropped while stalled")

endmodule

bind pid_deadband_feedforward_unit pdf_checker #(
    .DEADBAND (DEADBAND)
) u_pdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive       (drive),
    .in_deadband (in_deadband),
    .loop_error  (loop_error)
);

// ----- test/pid_deadband_feedforward_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_deadband_feedforward_unit_tb
// Self-checking bench for the PID deadband feedforward unit. Gains and limits
// go in over APB between phases. Samples are streamed with random gaps and
// output stalls. A fixed-point PID predictor works out the expected drive,
// deadband flag and loop error, and each output transfer is checked in order.
// ----------------------------------------------------------------------------
module pid_deadband_feedforward_unit_tb;
    import pdf_pkg::*;

    localparam int DEAD_BAND     = DEADBAND_DEF;
    localparam int FREEZE_MODE   = DEADBAND_FREEZE_DEF;
    localparam int RUN_LIMIT_NS  = 1_000_000;
    localparam int PHASE_COUNT   = 5;
    localparam int PHASE_SAMPLES = 160;
    localparam logic [2:0] REG_ORDER [8] = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
        REG_GAIN_FF, REG_INTEG_LOWER, REG_INTEG_UPPER, REG_DRIVE_LOWER,
        REG_DRIVE_UPPER};

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     dead;
        logic signed [ERR_W-1:0]  err;
    } drive_result_t;

    // Fixed-point PID predictor plus the queue of drive results still due
    class pid_drive_tracker;
        logic signed [DATA_W-1:0] gain_p, gain_i, gain_d, gain_ff;
        logic signed [ACC_W-1:0]  integ_lo, integ_hi;
        logic signed [DATA_W-1:0] drive_lo, drive_hi;
        longint                   accum, prior, held;
        drive_result_t            due_drives [$];
        int                       band;
        bit                       freeze;
        int                       errors;

        function new(int deadband, bit freeze_mode);
            band   = deadband;
            freeze = freeze_mode;
            gain_p = '0; gain_i = '0; gain_d = '0; gain_ff = '0;
            integ_lo = '0; integ_hi = '0; drive_lo = '0; drive_hi = '0;
            accum  = 0;
            prior  = 0;
            held   = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_GAIN_P:      gain_p   = val[DATA_W-1:0];
                REG_GAIN_I:      gain_i   = val[DATA_W-1:0];
                REG_GAIN_D:      gain_d   = val[DATA_W-1:0];
                REG_GAIN_FF:     gain_ff  = val[DATA_W-1:0];
                REG_INTEG_LOWER: integ_lo = val[ACC_W-1:0];
                REG_INTEG_UPPER: integ_hi = val[ACC_W-1:0];
                REG_DRIVE_LOWER: drive_lo = val[DATA_W-1:0];
                REG_DRIVE_UPPER: drive_hi = val[DATA_W-1:0];
                default: ;
            endcase
        endfunction

        // Limits may come in either order
        function longint order_clamp(longint v, longint a, longint b);
            longint lo, hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        function void note_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] ms,
                                  logic signed [DATA_W-1:0] ff);
            longint        e, mag, f_term, p_term, i_term, d_term, drv;
            drive_result_t res;
            e      = longint'(sp) - longint'(ms);
            mag    = (e < 0) ? -e : e;
            f_term = (longint'(gain_ff) * longint'(ff)) >>> 8;
            accum  = order_clamp(accum, longint'(integ_lo), longint'(integ_hi));
            res.dead = (mag <= longint'(band));
            if (res.dead) begin
                // clear mode drops the PID state, freeze mode keeps it
                if (!freeze) begin
                    accum = 0;
                    prior = 0;
                    held  = 0;
                end
            end
            else begin
                p_term = (longint'(gain_p) * e) >>> 8;
                accum  = order_clamp(accum + e, longint'(integ_lo), longint'(integ_hi));
                i_term = (longint'(gain_i) * accum) >>> 8;
                d_term = (longint'(gain_d) * (e - prior)) >>> 8;
                held   = p_term + i_term + d_term;
                prior  = e;
            end
            drv = order_clamp(held + f_term, longint'(drive_lo), longint'(drive_hi));
            res.drive = drv[DATA_W-1:0];
            res.err   = e[ERR_W-1:0];
            due_drives.push_back(res);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50)
                $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task check_drive(drive_result_t got);
            drive_result_t want;
            if (due_drives.size() == 0) begin
                report($sformatf("result with nothing due: drive %0d", got.drive));
            end
            else begin
                want = due_drives.pop_front();
                if (got.drive !== want.drive)
                    report($sformatf("drive %0d, expected %0d (err %0d)",
                                     got.drive, want.drive, want.err));
                if (got.dead !== want.dead)
                    report($sformatf("in_deadband %b, expected %b", got.dead, want.dead));
                if (got.err !== want.err)
                    report($sformatf("loop_error %0d, expected %0d", got.err, want.err));
            end
        endtask

        function int pending();
            return due_drives.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel, penable, pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       in_valid, in_stall;
    logic signed [DATA_W-1:0]   setpoint, measured, ff_sample;
    logic                       out_valid, out_stall;
    logic signed [DATA_W-1:0]   drive;
    logic                       in_deadband;
    logic signed [ERR_W-1:0]    loop_error;

    pid_drive_tracker tracker = new(DEAD_BAND, FREEZE_MODE != 0);
    bit               tx_calm;
    bit               rx_calm;

    pid_deadband_feedforward_unit #(
        .DEADBAND        (DEAD_BAND),
        .DEADBAND_FREEZE (FREEZE_MODE)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .setpoint    (setpoint),
        .measured    (measured),
        .ff_sample   (ff_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .in_deadband (in_deadband),
        .loop_error  (loop_error)
    );

    always #1 clk = ~clk;

    // Write all eight registers back to back; called at a rising edge
    task automatic program_regs(input int vals [8]);
        for (int k = 0; k < 8; k++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_ORDER[k], 2'b00};
            pwdata  <= vals[k];
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            tracker.set_reg(REG_ORDER[k], vals[k]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One input transfer after an optional idle gap
    task automatic push_sample(input logic signed [DATA_W-1:0] sp,
                               input logic signed [DATA_W-1:0] ms,
                               input logic signed [DATA_W-1:0] ff);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        setpoint  <= sp;
        measured  <= ms;
        ff_sample <= ff;
        do @(posedge clk); while (in_stall);
        tracker.note_sample(sp, ms, ff);
    endtask

    // Stop sending and wait for every due result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(bit narrow);
        if (narrow)
            return DATA_W'(int'($urandom_range(0, 600)) - 300);
        return DATA_W'($urandom());
    endfunction

    // Output side: check every transfer, then maybe stall a while
    initial
    begin
        int hold;
        int seen;
        out_stall <= 1'b0;
        rx_calm = 1'b0;
        seen = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                tracker.check_drive('{drive, in_deadband, loop_error});
                seen++;
                if (seen % 30 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                hold = rx_calm ? 0 : $urandom_range(0, 15);
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int                       cfg [8];
        logic signed [DATA_W-1:0] sp, ms;
        int                       kind;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        setpoint  <= '0;
        measured  <= '0;
        ff_sample <= '0;
        tx_calm   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                // unity-ish gains, wide limits
                0: cfg = '{256, 32, 128, 256, -100000, 100000, -32768, 32767};
                // extreme gains, both limit pairs reversed and full range
                1: cfg = '{32767, -32768, -32768, 32767,
                           32'h7FFF_FFFF, 32'h8000_0000, 32767, -32768};
                // opposite extremes, tight reversed limits
                2: cfg = '{-32768, 32767, 32767, -32768, 1000, -1000, 100, -200};
                // everything random
                3:
                begin
                    for (int k = 0; k < 4; k++) cfg[k] = int'(shortint'($urandom()));
                    cfg[4] = int'($urandom());
                    cfg[5] = int'($urandom());
                    cfg[6] = int'(shortint'($urandom()));
                    cfg[7] = int'(shortint'($urandom()));
                end
                // integrator pinned at zero, equal drive limits
                default:
                begin
                    for (int k = 0; k < 4; k++) cfg[k] = int'(shortint'($urandom()));
                    cfg[4] = 0;
                    cfg[5] = 0;
                    cfg[6] = 0;
                    cfg[7] = 0;
                end
            endcase
            program_regs(cfg);

            if (phase == 0)
            begin
                // deadband hit, then the largest errors of both signs
                push_sample(16'sd0, 16'sd0, 16'sd0);
                push_sample(16'sd32767, -16'sd32768, 16'sd32767);
                push_sample(16'sd32767, -16'sd32768, -16'sd32768);
                push_sample(16'sd32767, -16'sd32768, 16'sd0);
                push_sample(-16'sd32768, 16'sd32767, -16'sd32768);
                push_sample(-16'sd32768, 16'sd32767, 16'sd32767);
                // deadband with feedforward only, then the edges around it
                push_sample(16'sd5, 16'sd5, -16'sd32768);
                push_sample(16'sd1, 16'sd0, 16'sd0);
                push_sample(16'sd0, 16'sd1, 16'sd0);
                push_sample(16'sd32767, 16'sd32767, 16'sd32767);
                push_sample(-16'sd32768, -16'sd32768, -16'sd1);
                // integral wind-up against its limit, then the derivative kick
                for (int k = 0; k < 5; k++)
                    push_sample(16'sd30000, -16'sd30000, 16'sd100);
                push_sample(-16'sd30000, 16'sd30000, -16'sd100);
                push_sample(16'sd100, 16'sd0, -16'sd1);
                push_sample(-16'sd1, 16'sd0, 16'sd1);
                push_sample(16'sd0, 16'sd0, 16'sd32767);
                // sender holds off until the pipeline is empty
                drain_results();
            end

            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (n % 40 == 0)
                    tx_calm = ($urandom_range(0, 2) == 0);
                if (n == PHASE_SAMPLES / 2)
                    drain_results();
                kind = $urandom_range(0, 7);
                sp = pick_value(kind inside {[1:4]});
                ms = (kind == 0) ? sp : pick_value(kind inside {[1:4]});
                push_sample(sp, ms, pick_value($urandom_range(0, 1)));
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never came", tracker.pending()));
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
